[design/json_stream_writer_core_defines.svh]
// assertion helpers
`ifndef JSON_STREAM_WRITER_CORE_DEFINES_SVH
`define JSON_STREAM_WRITER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define JSW_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("json writer check failed");
`define JSW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("json writer check failed");
`else
`define JSW_ASSERT(lbl, expr)
`define JSW_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[design/jsw_pkg.sv]
package jsw_pkg;
	localparam int MAX_DEPTH_DEF = 8;
	localparam int INDENT_STEP_DEF = 4;
	localparam int IND_W = 6;
	localparam int INT_DIG = 20;

	typedef logic [3:0] mode_t;
	localparam mode_t MODE_OPEN_OBJ  = 4'd0;
	localparam mode_t MODE_CLOSE_OBJ = 4'd1;
	localparam mode_t MODE_OPEN_ARR  = 4'd2;
	localparam mode_t MODE_CLOSE_ARR = 4'd3;
	localparam mode_t MODE_KEY       = 4'd4;
	localparam mode_t MODE_STR       = 4'd5;
	localparam mode_t MODE_RAW       = 4'd6;
	localparam mode_t MODE_INT       = 4'd7;
	localparam mode_t MODE_BOOL      = 4'd8;
	localparam mode_t MODE_NULL      = 4'd9;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_KEY_NO_OBJ  = 3'd1;
	localparam status_t ST_CLOSE_EMPTY = 3'd2;
	localparam status_t ST_MISMATCH    = 3'd3;
	localparam status_t ST_SECOND_ROOT = 3'd4;
	localparam status_t ST_TOO_DEEP    = 3'd5;

	typedef enum logic [2:0] {BODY_NONE, BODY_BYTE, BODY_ESC, BODY_INT, BODY_LIT} body_t;
	typedef enum logic [1:0] {POST_NONE, POST_QUOTE, POST_KEY} post_t;
	typedef enum logic [1:0] {LIT_TRUE, LIT_FALSE, LIT_NULL} lit_t;

	typedef struct packed {
		mode_t              mode;
		logic [7:0]         text_byte;
		logic               has_byte;
		logic               first_of_text;
		logic               end_of_text;
		logic               escape_key;
		logic signed [63:0] int_value;
		logic               bool_value;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_result;
		status_t    status;
		logic       complete;
	} out_t;

	typedef struct packed {
		logic             comma;
		logic             newline;
		logic [IND_W-1:0] indent;
		logic             pre_en;
		logic [7:0]       pre_ch;
		body_t            body;
		logic [7:0]       text_byte;
		lit_t             lit;
		logic [63:0]      int_value;
		post_t            post;
		logic             space;
		status_t          status;
		logic             complete;
		logic             empty;
	} cmd_t;

	function automatic logic [7:0] esc_letter(input logic [7:0] c);
		logic [7:0] e;
		unique case (c)
			8'h22: e = 8'h22;
			8'h5c: e = 8'h5c;
			8'h2f: e = 8'h2f;
			8'h08: e = 8'h62;
			8'h0c: e = 8'h66;
			8'h0a: e = 8'h6e;
			8'h0d: e = 8'h72;
			8'h09: e = 8'h74;
			default: e = 8'h00;
		endcase
		return e;
	endfunction

	function automatic logic [7:0] lit_char(input lit_t sel, input logic [2:0] idx);
		logic [39:0] s;
		unique case (sel)
			LIT_TRUE:  s = {"true", 8'h00};
			LIT_FALSE: s = "false";
			default:   s = {"null", 8'h00};
		endcase
		return s[8'(39 - 8 * idx) -: 8];
	endfunction

	function automatic logic lit_end(input lit_t sel, input logic [2:0] idx);
		return (sel == LIT_FALSE) ? (idx == 3'd4) : (idx == 3'd3);
	endfunction
endpackage

[design/json_stream_writer_core.sv]
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   in_data  (in_t, one token)
// out       out  out_valid/out_stall out_data (out_t, one byte or status word)
// cfg       in   cfg_wr_en           cfg_wr_data (pretty layout)
// Front classifies a token combinationally and queues a command (4 deep).
// Back walks seven fixed slots per token (idle, comma, newline, prefix, body, suffix, end);
// indentation adds a slot per space plus one, literals a slot per letter, escape/colon/space
// one each, integers a BCD conversion and a digit scan. A status-only word goes idle to status.
// in_stall rises when the command queue is full; out_stall holds the back.
// Reset clears stack, flags and queue at once; no clearing pass.
`include "json_stream_writer_core_defines.svh"
module json_stream_writer_core import jsw_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF,
	parameter int INDENT_STEP = INDENT_STEP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);
	cmd_t cmd, head;
	logic take, full, empty, pop;

	assign in_stall = full;
	assign take = in_valid && !full;

	jsw_front #(.MAX_DEPTH(MAX_DEPTH), .INDENT_STEP(INDENT_STEP)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.take(take), .item(in_data), .cmd(cmd)
	);

	jsw_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(take), .push_data(cmd), .pop(pop),
		.head(head), .full(full), .empty(empty)
	);

	jsw_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(empty), .q_head(head), .q_pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	`JSW_ASSERT_IMP(a_stat_last, out_valid && !out_data.byte_valid, out_data.last_result)
	`JSW_ASSERT_IMP(a_err_nobyte, out_valid && out_data.status != ST_OK, !out_data.byte_valid)
	`JSW_ASSERT_IMP(a_done_ok, out_valid && out_data.complete, out_data.status == ST_OK)
	`JSW_ASSERT_IMP(a_pop_nonempty, pop, !empty)
endmodule

[design/jsw_front.sv]
module jsw_front import jsw_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF,
	parameter int INDENT_STEP = INDENT_STEP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	input  logic take,
	input  in_t  item,
	output cmd_t cmd
);
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam logic [IND_W:0] IND_MAX = (IND_W + 1)'(MAX_DEPTH * INDENT_STEP);
	localparam logic [IND_W:0] STEP = (IND_W + 1)'(INDENT_STEP);

	logic                 pretty_q;
	logic [MAX_DEPTH-1:0] arr_q, hv_q, arr_n, hv_n;
	logic [DW-1:0]        depth_q, depth_n;
	logic [IND_W-1:0]     ind_q, ind_n;
	logic                 root_q, root_n, err_q, err_n, td_q, td_n;
	logic [IW-1:0]        top;
	logic                 in_obj;
	status_t              tv_st, st;
	logic [IND_W:0]       ind_up;
	logic                 dropped;

	assign top = IW'(depth_q - DW'(1));
	assign in_obj = depth_q != '0;
	assign tv_st = (!in_obj && root_q) ? ST_SECOND_ROOT : ST_OK;
	assign ind_up = {1'b0, ind_q} + STEP;

	always_comb begin
		arr_n = arr_q;
		hv_n = hv_q;
		depth_n = depth_q;
		ind_n = ind_q;
		root_n = root_q;
		td_n = td_q;
		st = ST_OK;
		dropped = 1'b0;
		cmd = '0;
		cmd.indent = ind_q;
		cmd.text_byte = item.text_byte;
		cmd.int_value = item.int_value;
		cmd.space = pretty_q;
		cmd.lit = (item.mode == MODE_NULL) ? LIT_NULL : (item.bool_value ? LIT_TRUE : LIT_FALSE);
		priority if (item.mode <= MODE_CLOSE_ARR) begin
			td_n = 1'b0;
			if (item.mode == MODE_OPEN_OBJ || item.mode == MODE_OPEN_ARR) begin
				if (depth_q >= DW'(MAX_DEPTH)) begin
					st = ST_TOO_DEEP;
				end else begin
					st = tv_st;
					if (st == ST_OK) begin
						if (in_obj) begin
							cmd.comma = arr_q[top] & hv_q[top];
							cmd.newline = arr_q[top] & pretty_q;
							hv_n[top] = 1'b1;
						end else begin
							root_n = 1'b1;
						end
						arr_n[depth_q[IW-1:0]] = item.mode == MODE_OPEN_ARR;
						hv_n[depth_q[IW-1:0]] = 1'b0;
						depth_n = depth_q + DW'(1);
						cmd.pre_en = 1'b1;
						cmd.pre_ch = (item.mode == MODE_OPEN_ARR) ? 8'h5b : 8'h7b;
						ind_n = (ind_up > IND_MAX) ? IND_MAX[IND_W-1:0] : ind_up[IND_W-1:0];
					end
				end
			end else begin
				if (!in_obj) begin
					st = ST_CLOSE_EMPTY;
				end else begin
					depth_n = depth_q - DW'(1);
					if (arr_q[top] != (item.mode == MODE_CLOSE_ARR)) begin
						st = ST_MISMATCH;
					end else begin
						ind_n = ({1'b0, ind_q} >= STEP) ? IND_W'({1'b0, ind_q} - STEP) : '0;
						cmd.indent = ind_n;
						cmd.newline = pretty_q & hv_q[top];
						cmd.pre_en = 1'b1;
						cmd.pre_ch = (item.mode == MODE_CLOSE_ARR) ? 8'h5d : 8'h7d;
					end
				end
			end
		end else if (item.mode <= MODE_RAW) begin
			if (item.first_of_text) begin
				if (item.mode == MODE_KEY) begin
					if (!in_obj || arr_q[top]) begin
						st = ST_KEY_NO_OBJ;
					end else begin
						cmd.comma = hv_q[top];
						cmd.newline = pretty_q;
						cmd.pre_en = 1'b1;
						cmd.pre_ch = 8'h22;
					end
				end else begin
					st = tv_st;
					if (st == ST_OK) begin
						if (in_obj) begin
							cmd.comma = arr_q[top] & hv_q[top];
							cmd.newline = arr_q[top] & pretty_q;
							hv_n[top] = 1'b1;
						end else begin
							root_n = 1'b1;
						end
						cmd.pre_en = item.mode == MODE_STR;
						cmd.pre_ch = 8'h22;
					end
				end
				dropped = st != ST_OK;
			end else begin
				dropped = td_q;
			end
			if (!dropped) begin
				if (item.has_byte)
					cmd.body = (item.mode == MODE_STR || (item.mode == MODE_KEY && item.escape_key))
						? BODY_ESC : BODY_BYTE;
				if (item.end_of_text)
					cmd.post = (item.mode == MODE_KEY) ? POST_KEY :
						((item.mode == MODE_STR) ? POST_QUOTE : POST_NONE);
			end
			td_n = dropped & ~item.end_of_text;
		end else if (item.mode <= MODE_NULL) begin
			td_n = 1'b0;
			st = tv_st;
			if (st == ST_OK) begin
				if (in_obj) begin
					cmd.comma = arr_q[top] & hv_q[top];
					cmd.newline = arr_q[top] & pretty_q;
					hv_n[top] = 1'b1;
				end else begin
					root_n = 1'b1;
				end
				cmd.body = (item.mode == MODE_INT) ? BODY_INT : BODY_LIT;
			end
		end else begin
			// spare modes: no state change, plain status word
			td_n = td_q;
		end
		err_n = err_q | (st != ST_OK);
		cmd.status = st;
		cmd.complete = !err_n && depth_n == '0 && root_n;
		cmd.empty = !(cmd.comma || cmd.newline || cmd.pre_en || cmd.body != BODY_NONE ||
			cmd.post != POST_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pretty_q <= 1'b0;
			arr_q <= '0;
			hv_q <= '0;
			depth_q <= '0;
			ind_q <= '0;
			root_q <= 1'b0;
			err_q <= 1'b0;
			td_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				pretty_q <= cfg_wr_data;
			if (take) begin
				arr_q <= arr_n;
				hv_q <= hv_n;
				depth_q <= depth_n;
				ind_q <= ind_n;
				root_q <= root_n;
				err_q <= err_n;
				td_q <= td_n;
			end
		end
	end
endmodule

[design/jsw_queue.sv]
module jsw_queue import jsw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);
	cmd_t       mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

[design/jsw_back.sv]
module jsw_back import jsw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_COMMA, S_NL, S_SP, S_PRE, S_BODY, S_ESC2, S_LIT, S_CONV, S_DIG,
		S_POST, S_COLON, S_SPC, S_END, S_STAT
	} state_t;

	state_t           state_q;
	cmd_t             c_q;
	logic [IND_W-1:0] cnt_q;
	logic [2:0]       lidx_q;
	logic [5:0]       conv_q;
	logic [4:0]       didx_q;
	logic             started_q;
	logic [63:0]      mag_q;
	logic [4*INT_DIG-1:0] bcd_q;
	logic             h_valid_q;
	logic [7:0]       h_byte_q;
	logic             push_ok;
	logic [4*INT_DIG-1:0] bcd_adj;
	logic [3:0]       dig;

	assign push_ok = !out_valid || !out_stall;
	assign q_pop = state_q == S_IDLE && !q_empty && push_ok;
	assign dig = bcd_q[4 * didx_q +: 4];

	always_comb begin
		for (int i = 0; i < INT_DIG; i++)
			bcd_adj[4 * i +: 4] = (bcd_q[4 * i +: 4] >= 4'd5) ?
				bcd_q[4 * i +: 4] + 4'd3 : bcd_q[4 * i +: 4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic       em;
		logic [7:0] e;
		logic       ov;
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			h_valid_q <= 1'b0;
		end else begin
			em = 1'b0;
			e = 8'h00;
			// a stalled word stays, a drained one clears
			ov = out_valid && out_stall;
			if (push_ok) begin
				unique case (state_q)
					S_IDLE: begin
						if (!q_empty) begin
							c_q <= q_head;
							state_q <= q_head.empty ? S_STAT : S_COMMA;
						end
					end
					S_COMMA: begin
						em = c_q.comma;
						e = 8'h2c;
						state_q <= S_NL;
					end
					S_NL: begin
						if (c_q.newline) begin
							em = 1'b1;
							e = 8'h0a;
							cnt_q <= c_q.indent;
							state_q <= S_SP;
						end else begin
							state_q <= S_PRE;
						end
					end
					S_SP: begin
						if (cnt_q == '0) begin
							state_q <= S_PRE;
						end else begin
							em = 1'b1;
							e = 8'h20;
							cnt_q <= cnt_q - IND_W'(1);
						end
					end
					S_PRE: begin
						em = c_q.pre_en;
						e = c_q.pre_ch;
						state_q <= S_BODY;
					end
					S_BODY: begin
						unique case (c_q.body)
							BODY_BYTE: begin
								em = 1'b1;
								e = c_q.text_byte;
								state_q <= S_POST;
							end
							BODY_ESC: begin
								em = 1'b1;
								if (esc_letter(c_q.text_byte) != 8'h00) begin
									e = 8'h5c;
									state_q <= S_ESC2;
								end else begin
									e = c_q.text_byte;
									state_q <= S_POST;
								end
							end
							BODY_LIT: begin
								lidx_q <= '0;
								state_q <= S_LIT;
							end
							BODY_INT: begin
								em = c_q.int_value[63];
								e = 8'h2d;
								mag_q <= c_q.int_value[63] ? ~c_q.int_value + 64'd1 : c_q.int_value;
								bcd_q <= '0;
								conv_q <= '0;
								state_q <= S_CONV;
							end
							default: state_q <= S_POST;
						endcase
					end
					S_ESC2: begin
						em = 1'b1;
						e = esc_letter(c_q.text_byte);
						state_q <= S_POST;
					end
					S_LIT: begin
						em = 1'b1;
						e = lit_char(c_q.lit, lidx_q);
						lidx_q <= lidx_q + 3'd1;
						if (lit_end(c_q.lit, lidx_q))
							state_q <= S_POST;
					end
					S_CONV: begin
						{bcd_q, mag_q} <= {bcd_adj[4*INT_DIG-2:0], mag_q, 1'b0};
						conv_q <= conv_q + 6'd1;
						if (conv_q == 6'd63) begin
							didx_q <= 5'(INT_DIG - 1);
							started_q <= 1'b0;
							state_q <= S_DIG;
						end
					end
					S_DIG: begin
						if (dig != 4'd0 || started_q || didx_q == '0) begin
							em = 1'b1;
							e = {4'h3, dig};
							started_q <= 1'b1;
						end
						if (didx_q == '0)
							state_q <= S_POST;
						else
							didx_q <= didx_q - 5'd1;
					end
					S_POST: begin
						unique case (c_q.post)
							POST_QUOTE: begin
								em = 1'b1;
								e = 8'h22;
								state_q <= S_END;
							end
							POST_KEY: begin
								em = 1'b1;
								e = 8'h22;
								state_q <= S_COLON;
							end
							default: state_q <= S_END;
						endcase
					end
					S_COLON: begin
						em = 1'b1;
						e = 8'h3a;
						state_q <= c_q.space ? S_SPC : S_END;
					end
					S_SPC: begin
						em = 1'b1;
						e = 8'h20;
						state_q <= S_END;
					end
					S_END: begin
						ov = 1'b1;
						out_data <= '{out_byte: h_byte_q, byte_valid: 1'b1, last_result: 1'b1,
							status: ST_OK, complete: c_q.complete};
						h_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
					S_STAT: begin
						ov = 1'b1;
						out_data <= '{out_byte: 8'h00, byte_valid: 1'b0, last_result: 1'b1,
							status: c_q.status, complete: c_q.complete};
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
				if (em) begin
					if (h_valid_q) begin
						ov = 1'b1;
						out_data <= '{out_byte: h_byte_q, byte_valid: 1'b1, last_result: 1'b0,
							status: ST_OK, complete: c_q.complete};
					end
					h_valid_q <= 1'b1;
					h_byte_q <= e;
				end
			end
			out_valid <= ov;
		end
	end
endmodule

[sim/json_stream_writer_core_check.sv]
module json_stream_writer_core_check import jsw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	input  logic in_valid,
	input  logic in_stall,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  out_t out_data,
	output int   fails,
	output int   pending,
	output int   words_in,
	output int   words_out
);
	localparam int DEPTH = MAX_DEPTH_DEF;
	localparam int STEP = INDENT_STEP_DEF;
	localparam int INDENT_CAP = DEPTH * STEP;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_FF = 8'h0c;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	logic pretty;
	logic lvl_arr [DEPTH];
	logic lvl_val [DEPTH];
	int nest;
	int indent;
	logic root_done;
	logic err_sticky;
	logic skip_text;
	logic [7:0] text_out [$];
	out_t words_due [$];

	initial begin
		fails = 0;
		words_in = 0;
		words_out = 0;
		pending = 0;
	end

	task automatic put(input logic [7:0] c);
		text_out.insert(text_out.size(), c);
	endtask

	task automatic put_break();
		put(CH_LF);
		for (int k = 0; k < indent; k++)
			put(CH_SPACE);
	endtask

	task automatic put_esc(input logic [7:0] c);
		logic [7:0] e;
		case (c)
			CH_QUOTE: e = CH_QUOTE;
			CH_BSLASH: e = CH_BSLASH;
			CH_SLASH: e = CH_SLASH;
			CH_BS: e = "b";
			CH_FF: e = "f";
			CH_LF: e = "n";
			CH_CR: e = "r";
			CH_TAB: e = "t";
			default: e = 8'h00;
		endcase
		if (e != 8'h00) begin
			put(CH_BSLASH);
			put(e);
		end else begin
			put(c);
		end
	endtask

	task automatic put_str(input string s);
		for (int k = 0; k < s.len(); k++)
			put(s[k]);
	endtask

	task automatic put_dec(input logic [63:0] v);
		logic [63:0] mag;
		logic [7:0] dig [$];
		mag = v;
		if (v[63]) begin
			put("-");
			mag = ~v + 64'd1;
		end
		do begin
			dig.push_front(8'(mag % 64'd10) + "0");
			mag = mag / 64'd10;
		end while (mag != 0);
		foreach (dig[k])
			put(dig[k]);
	endtask

	task automatic add_value(output status_t st);
		int t;
		st = ST_OK;
		if (nest == 0) begin
			if (root_done)
				st = ST_SECOND_ROOT;
			else
				root_done = 1'b1;
		end else begin
			t = nest - 1;
			if (lvl_arr[t]) begin
				if (lvl_val[t])
					put(",");
				if (pretty)
					put_break();
			end
			lvl_val[t] = 1'b1;
		end
	endtask

	task automatic predict_token(input in_t d);
		status_t st;
		logic drop;
		logic fin;
		out_t w;
		st = ST_OK;
		text_out.delete();
		if (d.mode <= MODE_CLOSE_ARR) begin
			skip_text = 1'b0;
			if (d.mode == MODE_OPEN_OBJ || d.mode == MODE_OPEN_ARR) begin
				if (nest >= DEPTH) begin
					st = ST_TOO_DEEP;
				end else begin
					add_value(st);
					if (st == ST_OK) begin
						lvl_arr[nest] = (d.mode == MODE_OPEN_ARR);
						lvl_val[nest] = 1'b0;
						nest++;
						put(d.mode == MODE_OPEN_ARR ? "[" : "{");
						indent = (indent + STEP > INDENT_CAP) ? INDENT_CAP : indent + STEP;
					end
				end
			end else if (nest == 0) begin
				st = ST_CLOSE_EMPTY;
			end else begin
				nest--;
				if (lvl_arr[nest] != (d.mode == MODE_CLOSE_ARR)) begin
					st = ST_MISMATCH;
				end else begin
					indent = (indent >= STEP) ? indent - STEP : 0;
					if (pretty && lvl_val[nest])
						put_break();
					put(d.mode == MODE_CLOSE_ARR ? "]" : "}");
				end
			end
		end else if (d.mode <= MODE_RAW) begin
			if (d.first_of_text) begin
				if (d.mode == MODE_KEY) begin
					if (nest == 0 || lvl_arr[nest-1]) begin
						st = ST_KEY_NO_OBJ;
					end else begin
						if (lvl_val[nest-1])
							put(",");
						if (pretty)
							put_break();
						put(CH_QUOTE);
					end
				end else begin
					add_value(st);
					if (st == ST_OK && d.mode == MODE_STR)
						put(CH_QUOTE);
				end
				drop = (st != ST_OK);
			end else begin
				drop = skip_text;
			end
			if (!drop) begin
				if (d.has_byte) begin
					if (d.mode == MODE_STR || (d.mode == MODE_KEY && d.escape_key))
						put_esc(d.text_byte);
					else
						put(d.text_byte);
				end
				if (d.end_of_text) begin
					if (d.mode == MODE_KEY) begin
						put(CH_QUOTE);
						put(":");
						if (pretty)
							put(CH_SPACE);
					end else if (d.mode == MODE_STR) begin
						put(CH_QUOTE);
					end
				end
			end
			skip_text = drop && !d.end_of_text;
		end else if (d.mode <= MODE_NULL) begin
			skip_text = 1'b0;
			add_value(st);
			if (st == ST_OK) begin
				if (d.mode == MODE_INT)
					put_dec(d.int_value);
				else if (d.mode == MODE_BOOL)
					put_str(d.bool_value ? "true" : "false");
				else
					put_str("null");
			end
		end
		if (st != ST_OK)
			err_sticky = 1'b1;
		fin = !err_sticky && nest == 0 && root_done;
		if (text_out.size() == 0) begin
			w = '{out_byte: 8'h00, byte_valid: 1'b0, last_result: 1'b1, status: st,
				complete: fin};
			words_due.insert(words_due.size(), w);
		end
		foreach (text_out[k]) begin
			w = '{out_byte: text_out[k], byte_valid: 1'b1,
				last_result: (k == text_out.size() - 1), status: ST_OK, complete: fin};
			words_due.insert(words_due.size(), w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			pretty = 1'b0;
			foreach (lvl_arr[k]) begin
				lvl_arr[k] = 1'b0;
				lvl_val[k] = 1'b0;
			end
			nest = 0;
			indent = 0;
			root_done = 1'b0;
			err_sticky = 1'b0;
			skip_text = 1'b0;
			words_due.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				words_out++;
				if (words_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected word: byte %h valid %b last %b st %0d cpl %b",
							out_data.out_byte, out_data.byte_valid, out_data.last_result,
							out_data.status, out_data.complete);
				end else begin
					want = words_due.pop_front();
					if (out_data.out_byte !== want.out_byte ||
						out_data.byte_valid !== want.byte_valid ||
						out_data.last_result !== want.last_result ||
						out_data.status !== want.status ||
						out_data.complete !== want.complete) begin
						fails++;
						if (fails <= 10)
							$display({"word %0d mismatch: byte %h/%h valid %b/%b last %b/%b",
								" st %0d/%0d cpl %b/%b (expected/actual)"}, words_out,
								want.out_byte, out_data.out_byte, want.byte_valid,
								out_data.byte_valid, want.last_result, out_data.last_result,
								want.status, out_data.status, want.complete, out_data.complete);
					end
				end
			end
			if (in_valid && !in_stall) begin
				words_in++;
				predict_token(in_data);
			end
			if (cfg_wr_en)
				pretty = cfg_wr_data;
			pending = words_due.size();
		end
	end
endmodule

[sim/json_stream_writer_core_test.sv]
module json_stream_writer_core_test import jsw_pkg::*; ();
	localparam int RAND_ITEMS = 128;
	localparam int QUIET_LIMIT = 6000;
	localparam int HOLD_OFF = 200;
	localparam int MODE_SPARE_LO = 10;
	localparam int MODE_SPARE_HI = 15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	int fails, pending, words_in, words_out;
	int quiet = 0;
	int sent = 0;
	logic calm = 1'b0;
	logic kind_arr [16];
	int tdepth;
	logic want_value;

	always #4 clk = ~clk;

	json_stream_writer_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	json_stream_writer_core_check u_check (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fails(fails), .pending(pending), .words_in(words_in), .words_out(words_out)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int w;
		logic acc;
		@(posedge arst_n);
		forever begin
			w = (words_out % 60 < 15) ? 0 : $urandom_range(0, 13);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				acc = out_valid;
				@(posedge clk);
			end while (!acc);
		end
	end

	task automatic send(input in_t d);
		int gap;
		logic acc;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		sent++;
		do begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
		end while (!acc);
	endtask

	function automatic in_t tok(input mode_t m);
		in_t d;
		d = '0;
		d.mode = m;
		return d;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] spec [9] = '{8'h22, 8'h5c, 8'h2f, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h41};
		return ($urandom_range(0, 1) == 0) ? spec[$urandom_range(0, 8)] : 8'($urandom);
	endfunction

	task automatic text1(input mode_t m, input logic [7:0] b, input logic esc,
		input logic first, input logic last);
		in_t d;
		d = tok(m);
		d.text_byte = b;
		d.has_byte = 1'b1;
		d.escape_key = esc;
		d.first_of_text = first;
		d.end_of_text = last;
		send(d);
	endtask

	task automatic rand_text(input mode_t m);
		int n;
		in_t d;
		n = $urandom_range(1, 4);
		for (int k = 0; k < n; k++) begin
			d = tok(m);
			d.text_byte = pick_byte();
			d.has_byte = ($urandom_range(0, 7) != 0);
			d.escape_key = 1'($urandom_range(0, 1));
			d.first_of_text = (k == 0);
			d.end_of_text = (k == n - 1);
			send(d);
		end
	endtask

	task automatic scalar(input mode_t m, input logic [63:0] v, input logic b);
		in_t d;
		d = tok(m);
		d.int_value = v;
		d.bool_value = b;
		send(d);
	endtask

	task automatic rand_scalar();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = 64'($urandom_range(0, 999));
			1: v = {$urandom, $urandom};
			2: v = -64'($urandom_range(1, 99999));
			default: v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		endcase
		case ($urandom_range(0, 2))
			0: scalar(MODE_INT, v, 1'b0);
			1: scalar(MODE_BOOL, v, 1'($urandom_range(0, 1)));
			default: scalar(MODE_NULL, v, 1'b0);
		endcase
	endtask

	task automatic set_pretty(input logic v);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (HOLD_OFF) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic rand_step();
		in_t d;
		int r;
		logic a;
		logic [95:0] raw;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			raw = {$urandom, $urandom, $urandom};
			d = raw[$bits(in_t)-1:0];
			d.mode = mode_t'($urandom_range(MODE_KEY, MODE_SPARE_HI));
			send(d);
		end else if (!kind_arr[tdepth-1] && !want_value) begin
			rand_text(($urandom_range(0, 15) == 0) ? MODE_STR : MODE_KEY);
			want_value = 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				rand_scalar();
			end else if (r < 50) begin
				rand_text(MODE_STR);
			end else if (r < 58) begin
				rand_text(MODE_RAW);
			end else if (r < 78) begin
				a = 1'($urandom_range(0, 1));
				send(tok(a ? MODE_OPEN_ARR : MODE_OPEN_OBJ));
				if (tdepth < MAX_DEPTH_DEF) begin
					kind_arr[tdepth] = a;
					tdepth++;
				end
			end else if (tdepth > 1 && !want_value) begin
				a = ($urandom_range(0, 9) == 0) ? !kind_arr[tdepth-1] : kind_arr[tdepth-1];
				send(tok(a ? MODE_CLOSE_ARR : MODE_CLOSE_OBJ));
				tdepth--;
			end else begin
				rand_scalar();
			end
			want_value = 1'b0;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		set_pretty(1'b0);

		send(tok(MODE_OPEN_OBJ));
		text1(MODE_KEY, 8'h22, 1'b1, 1'b1, 1'b1);
		text1(MODE_STR, 8'h5c, 1'b0, 1'b1, 1'b0);
		text1(MODE_STR, 8'h2f, 1'b0, 1'b0, 1'b0);
		text1(MODE_STR, 8'h08, 1'b0, 1'b0, 1'b1);
		text1(MODE_KEY, 8'h0a, 1'b0, 1'b1, 1'b1);
		send('{mode: MODE_STR, text_byte: 8'hff, has_byte: 1'b0, first_of_text: 1'b1,
			end_of_text: 1'b1, escape_key: 1'b0, int_value: 64'd0, bool_value: 1'b0});
		scalar(MODE_INT, 64'h8000_0000_0000_0000, 1'b0);
		scalar(MODE_INT, 64'h7fff_ffff_ffff_ffff, 1'b0);
		scalar(MODE_INT, 64'd0, 1'b0);
		scalar(MODE_INT, '1, 1'b0);
		scalar(MODE_BOOL, '0, 1'b1);
		scalar(MODE_BOOL, '0, 1'b0);
		send(tok(MODE_OPEN_ARR));
		text1(MODE_KEY, 8'h61, 1'b1, 1'b1, 1'b0);
		text1(MODE_KEY, 8'h62, 1'b1, 1'b0, 1'b1);
		text1(MODE_RAW, 8'hff, 1'b0, 1'b1, 1'b0);
		text1(MODE_RAW, 8'h0a, 1'b0, 1'b0, 1'b1);
		text1(MODE_STR, 8'h0c, 1'b0, 1'b1, 1'b0);
		text1(MODE_STR, 8'h0d, 1'b0, 1'b0, 1'b0);
		text1(MODE_STR, 8'h09, 1'b0, 1'b0, 1'b0);
		text1(MODE_STR, 8'h0a, 1'b0, 1'b0, 1'b1);
		scalar(MODE_NULL, '0, 1'b0);
		send(tok(MODE_CLOSE_OBJ));
		repeat (MAX_DEPTH_DEF) send(tok(MODE_OPEN_ARR));
		repeat (MAX_DEPTH_DEF - 1) send(tok(MODE_CLOSE_ARR));
		send(tok(mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))));

		kind_arr[0] = 1'b0;
		tdepth = 1;
		want_value = 1'b0;
		sent = 0;
		set_pretty(1'b1);
		while (sent < RAND_ITEMS / 2) begin
			calm = (sent % 50) < 12;
			rand_step();
		end
		set_pretty(1'b0);
		while (sent < RAND_ITEMS) begin
			calm = (sent % 50) < 12;
			rand_step();
		end
		set_pretty(1'b1);
		calm = 1'b0;
		if (want_value)
			scalar(MODE_NULL, '0, 1'b0);
		while (tdepth > 0) begin
			tdepth--;
			send(tok(kind_arr[tdepth] ? MODE_CLOSE_ARR : MODE_CLOSE_OBJ));
		end
		send(tok(MODE_CLOSE_ARR));
		scalar(MODE_NULL, '0, 1'b0);
		text1(MODE_KEY, 8'h7a, 1'b1, 1'b1, 1'b1);
		send(tok(mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))));
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (HOLD_OFF) @(posedge clk);

		$display("run: %0d tokens in, %0d words out, compact and pretty layout", words_in,
			words_out);
		$display("deep nesting, escapes, integer extremes and all error codes driven");
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

[sim.f]
+incdir+design
design/jsw_pkg.sv
design/jsw_front.sv
design/jsw_queue.sv
design/jsw_back.sv
design/json_stream_writer_core.sv
sim/json_stream_writer_core_check.sv
sim/json_stream_writer_core_test.sv
